// ===== src/gdd_pkg.sv =====
package gdd_pkg;

  localparam logic [2:0] MODE_DAYS    = 3'd0;
  localparam logic [2:0] MODE_WEEKS   = 3'd1;
  localparam logic [2:0] MODE_MONTHS  = 3'd2;
  localparam logic [2:0] MODE_YEARS   = 3'd3;
  localparam logic [2:0] MODE_DECADES = 3'd4;

  localparam int          STEP_W       = 18;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  localparam logic [4:0]  DAY_LAST_DEC = 5'd31;
  localparam logic [4:0]  RES25_MAX    = 5'd24;
  localparam logic [4:0]  RES25_WRAP   = 5'd17;
  localparam logic [4:0]  RES25_NEG    = 5'd11;
  localparam logic [4:0]  RES25_NEGC   = 5'd14;
  localparam logic [11:0] RECIP25      = 12'd2622;
  localparam logic [15:0] YEAR_MIN     = 16'h8000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_free;
  } status_t;

  // res25 is the year modulo 25 as a nonnegative residue
  function automatic logic is_leap(input logic [15:0] year, input logic [4:0] res25);
    is_leap = (year[1:0] == 2'b00) && ((res25 != 5'd0) || (year[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 5'd30;
      4'd2:                                      month_len = leap ? 5'd29 : 5'd28;
      default:                                   month_len = 5'd0;
    endcase
  endfunction

endpackage

// ===== src/gregorian_date_decrement.sv =====
// each input word is walked back to its result word in n steps of one day or one month
// n is count (days, months), 7 * count (weeks), 0 (years, decades, unused modes)
// a new word is taken only once the last has left the single day/month step unit
// a finished word waits in the output register while the next word is taken
// reset (rst_n low, synchronous) empties the block and clears out_valid
module gregorian_date_decrement import gdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [14:0]        in_count,
  input  logic [4:0]         in_day_in,
  input  logic [3:0]         in_month_in,
  input  logic signed [15:0] in_year_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_day_out,
  output logic [3:0]         out_month_out,
  output logic signed [15:0] out_year_out
);

  cmd_t    cmd;
  status_t sts;

  gdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gdd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_count      (in_count),
    .in_day_in     (in_day_in),
    .in_month_in   (in_month_in),
    .in_year_in    (in_year_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_day_out   (out_day_out),
    .out_month_out (out_month_out),
    .out_year_out  (out_year_out)
  );

endmodule

// ===== src/gdd_ctrl.sv =====
module gdd_ctrl import gdd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (sts.cnt_zero && sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
      end
      S_RUN: begin
        cmd.step   = !sts.cnt_zero;
        cmd.finish = sts.cnt_zero && sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/gdd_dp.sv =====
module gdd_dp import gdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic [2:0]         in_mode,
  input  logic [14:0]        in_count,
  input  logic [4:0]         in_day_in,
  input  logic [3:0]         in_month_in,
  input  logic signed [15:0] in_year_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_day_out,
  output logic [3:0]         out_month_out,
  output logic signed [15:0] out_year_out
);

  logic [4:0]        day_r, day_nxt;
  logic [3:0]        month_r, month_nxt;
  logic [15:0]       year_r, year_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [4:0]        res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [4:0]        oday_r, oday_nxt;
  logic [3:0]        omonth_r, omonth_nxt;
  logic [15:0]       oyear_r, oyear_nxt;

  logic [STEP_W-1:0] cnt_ext;
  logic [15:0]       cnt16;
  logic [10:0]       fold;
  logic [22:0]       prod;
  logic [6:0]        quo;
  logic [10:0]       quo25;
  logic [4:0]        rem_u;
  logic              leap_now;
  logic [3:0]        month_dec;
  logic [4:0]        len_dec;
  logic [15:0]       year_dec;
  logic [4:0]        res_dec;

  assign cnt_ext  = {3'b000, in_count};
  assign cnt16    = {1'b0, in_count};

  // year mod 25 from the 16-bit pattern: 256 = 6 mod 25, then reciprocal divide
  assign fold     = 11'({3'b000, year_r[15:8]} * 11'd6) + {3'b000, year_r[7:0]};
  assign prod     = {12'd0, fold} * {11'd0, RECIP25};
  assign quo      = prod[22:16];
  assign quo25    = 11'({4'b0000, quo} * 11'd25);
  assign rem_u    = 5'(fold - quo25);

  assign leap_now  = is_leap(year_r, res_r);
  assign month_dec = month_r - 4'd1;
  assign len_dec   = month_len(month_dec, leap_now);
  assign year_dec  = year_r - 16'd1;
  assign res_dec   = (year_r == YEAR_MIN) ? RES25_WRAP :
                     (res_r == 5'd0) ? RES25_MAX : res_r - 5'd1;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    if (cmd.load) begin
      day_nxt   = in_day_in;
      month_nxt = in_month_in;
      year_nxt  = in_year_in;
      mode_nxt  = in_mode;
      cnt_nxt   = '0;
      case (in_mode)
        MODE_DAYS:    cnt_nxt = cnt_ext;
        MODE_WEEKS:   cnt_nxt = (cnt_ext << 3) - cnt_ext;
        MODE_MONTHS:  cnt_nxt = cnt_ext;
        MODE_YEARS:   year_nxt = in_year_in - cnt16;
        MODE_DECADES: year_nxt = in_year_in - ((cnt16 << 3) + (cnt16 << 1));
        default:      cnt_nxt = '0;
      endcase
    end else if (cmd.prep) begin
      if (year_r[15]) begin
        res_nxt = (rem_u >= RES25_NEG) ? rem_u - RES25_NEG : rem_u + RES25_NEGC;
      end else begin
        res_nxt = rem_u;
      end
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - {{(STEP_W-1){1'b0}}, 1'b1};
      if (mode_r == MODE_MONTHS) begin
        if (month_r == MONTH_JAN) begin
          month_nxt = MONTH_DEC;
          year_nxt  = year_dec;
          res_nxt   = res_dec;
        end else begin
          month_nxt = month_dec;
          if (day_r > len_dec) day_nxt = len_dec;
        end
      end else begin
        if (day_r == DAY_FIRST) begin
          if (month_r == MONTH_JAN) begin
            month_nxt = MONTH_DEC;
            day_nxt   = DAY_LAST_DEC;
            year_nxt  = year_dec;
            res_nxt   = res_dec;
          end else begin
            month_nxt = month_dec;
            day_nxt   = len_dec;
          end
        end else begin
          day_nxt = day_r - 5'd1;
        end
      end
    end
  end

  always_comb begin
    oday_nxt      = oday_r;
    omonth_nxt    = omonth_r;
    oyear_nxt     = oyear_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.finish) begin
      oday_nxt      = day_r;
      omonth_nxt    = month_r;
      oyear_nxt     = year_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r    <= day_nxt;
    month_r  <= month_nxt;
    year_r   <= year_nxt;
    mode_r   <= mode_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    oday_r   <= oday_nxt;
    omonth_r <= omonth_nxt;
    oyear_r  <= oyear_nxt;
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_day_out   = oday_r;
  assign out_month_out = omonth_r;
  assign out_year_out  = oyear_r;

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdd_pkg::*;

  localparam int IDLE_LIMIT = 700000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 450;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic signed [15:0] year;
  } date_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [14:0] in_count = '0;
  logic [4:0] in_day_in = '0;
  logic [3:0] in_month_in = '0;
  logic signed [15:0] in_year_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] out_day_out;
  logic [3:0] out_month_out;
  logic signed [15:0] out_year_out;

  date_t earlier_dates[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  gregorian_date_decrement DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_count(in_count),
    .in_day_in(in_day_in),
    .in_month_in(in_month_in),
    .in_year_in(in_year_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_day_out(out_day_out),
    .out_month_out(out_month_out),
    .out_year_out(out_year_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic date_t mk_date(int d, int m, int y);
    date_t dt;
    dt.day = d[4:0];
    dt.month = m[3:0];
    dt.year = y[15:0];
    return dt;
  endfunction

  function automatic bit leap_year(logic signed [15:0] y);
    int yy;
    yy = int'(y);
    return ((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0);
  endfunction

  function automatic logic [4:0] days_in_month(logic [3:0] m, logic signed [15:0] y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      4'd2: return leap_year(y) ? 5'd29 : 5'd28;
      default: return 5'd0;
    endcase
  endfunction

  function automatic date_t step_back_date(logic [2:0] mode, logic [14:0] count,
                                           date_t start);
    date_t dt;
    int unsigned steps;
    int unsigned i;
    logic [4:0] len;
    dt = start;
    steps = {17'd0, count};
    case (mode)
      MODE_DAYS, MODE_WEEKS: begin
        if (mode == MODE_WEEKS) steps = steps * 7;
        for (i = 0; i < steps; i++) begin
          if (dt.day == 5'd1) begin
            if (dt.month == 4'd1) begin
              dt.month = 4'd12;
              dt.day = 5'd31;
              dt.year = dt.year - 16'd1;
            end else begin
              dt.month = dt.month - 4'd1;
              dt.day = days_in_month(dt.month, dt.year);
            end
          end else begin
            dt.day = dt.day - 5'd1;
          end
        end
      end
      MODE_MONTHS: begin
        for (i = 0; i < steps; i++) begin
          if (dt.month == 4'd1) begin
            dt.month = 4'd12;
            dt.year = dt.year - 16'd1;
          end else begin
            dt.month = dt.month - 4'd1;
          end
          len = days_in_month(dt.month, dt.year);
          if (dt.day > len) dt.day = len;
        end
      end
      MODE_YEARS: dt.year = 16'(dt.year - steps);
      MODE_DECADES: begin
        steps = steps * 10;
        dt.year = 16'(dt.year - steps);
      end
      default: ;
    endcase
    return dt;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_word(logic [2:0] mode, logic [14:0] count, date_t start);
    int gap;
    gap = (!quiet && $urandom_range(99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_count <= count;
    in_day_in <= start.day;
    in_month_in <= start.month;
    in_year_in <= start.year;
    do @(posedge clk); while (in_stall !== 1'b0);
    earlier_dates.push_back(step_back_date(mode, count, start));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (earlier_dates.size() != 0) @(posedge clk);
  endtask

  // result word checker
  always @(posedge clk) begin
    date_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (earlier_dates.size() == 0) begin
        $display("%0t: result word with nothing expected: %0d/%0d/%0d", $time,
                 out_day_out, out_month_out, out_year_out);
        errors++;
      end else begin
        want = earlier_dates.pop_front();
        if (out_day_out !== want.day) begin
          $display("%0t: day mismatch, expected %0d, actual %0d", $time,
                   want.day, out_day_out);
          errors++;
        end
        if (out_month_out !== want.month) begin
          $display("%0t: month mismatch, expected %0d, actual %0d", $time,
                   want.month, out_month_out);
          errors++;
        end
        if (out_year_out !== want.year) begin
          $display("%0t: year mismatch, expected %0d, actual %0d", $time,
                   want.year, out_year_out);
          errors++;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && rst_n === 1'b1 && $urandom_range(99) < 25) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("gregorian_date_decrement verification failed");
      $finish;
    end
  end

  task automatic test_reset();
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_day_rollover();
    send_word(MODE_DAYS, 15'd0, mk_date(15, 6, 2023));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 1, 2000));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 3, 2000));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 3, 1900));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 3, -4));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 3, -400));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 1, -32768));
    send_word(MODE_WEEKS, 15'd1, mk_date(5, 1, 2021));
    send_word(MODE_DAYS, 15'd366, mk_date(31, 12, 2024));
  endtask

  task automatic test_month_clamp();
    send_word(MODE_MONTHS, 15'd1, mk_date(31, 3, 2023));
    send_word(MODE_MONTHS, 15'd1, mk_date(31, 3, 2024));
    send_word(MODE_MONTHS, 15'd1, mk_date(15, 1, -32768));
    send_word(MODE_MONTHS, 15'd13, mk_date(31, 12, 2000));
  endtask

  task automatic test_year_modes();
    send_word(MODE_YEARS, 15'd1, mk_date(29, 2, 2024));
    send_word(MODE_DECADES, 15'd32767, mk_date(1, 1, 0));
    send_word(MODE_YEARS, 15'd32767, mk_date(31, 12, -32768));
  endtask

  task automatic test_unused_and_invalid();
    send_word(3'd5, 15'd32767, mk_date(31, 12, 32767));
    send_word(3'd7, 15'd32767, mk_date(1, 1, -32768));
    send_word(MODE_DAYS, 15'd1, mk_date(0, 5, 2001));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 0, 2001));
    send_word(MODE_DAYS, 15'd1, mk_date(1, 13, 2001));
    send_word(MODE_MONTHS, 15'd1, mk_date(31, 0, 2001));
  endtask

  task automatic test_long_counts();
    wait_drained();
    send_word(MODE_WEEKS, 15'd32767, mk_date(31, 12, 32767));
    send_word(MODE_DAYS, 15'd32767, mk_date(1, 1, -32768));
    send_word(MODE_MONTHS, 15'd32767, mk_date(31, 12, 32767));
  endtask

  task automatic test_random_dates();
    int n;
    int r;
    logic [2:0] mode;
    logic [14:0] count;
    date_t start;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 150 && n < 210);
      if (n == 300) wait_drained();
      r = $urandom_range(99);
      if (r < 85) begin
        mode = 3'($urandom_range(4));
        start.month = 4'($urandom_range(12, 1));
        start.year = 16'(($urandom_range(99) < 10) ? 16'h8000 + $urandom_range(3)
                                                   : $urandom_range(16'hffff));
        start.day = 5'($urandom_range(days_in_month(start.month, start.year), 1));
        r = $urandom_range(99);
        case (mode)
          MODE_YEARS, MODE_DECADES: count = 15'($urandom_range(32767));
          MODE_WEEKS: count = 15'((r < 95) ? $urandom_range(40) : $urandom_range(1500));
          default: count = 15'((r < 90) ? $urandom_range(60) :
                               (r < 99) ? $urandom_range(1500) : $urandom_range(32767));
        endcase
      end else begin
        mode = 3'($urandom_range(7));
        count = 15'($urandom_range(60));
        start.day = 5'($urandom_range(31));
        start.month = 4'($urandom_range(15));
        start.year = 16'($urandom_range(16'hffff));
      end
      send_word(mode, count, start);
    end
    quiet = 1'b0;
  endtask

  initial begin
    test_reset();
    test_day_rollover();
    test_month_clamp();
    test_year_modes();
    test_unused_and_invalid();
    test_long_counts();
    test_random_dates();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("gregorian_date_decrement verification clean");
    end else begin
      $display("gregorian_date_decrement verification failed");
    end
    $finish;
  end

endmodule
